/* hdl/pfa_pkg.sv */
// Shared types, constants and helpers for the bitmap page frame allocator.
// No dependencies; every other file in hdl imports this package.
`default_nettype none
package pfa_pkg;

	localparam int NUM_FRAMES = 1024;
	localparam int PAGE_SHIFT = 12;

	// Field widths of the stream items
	localparam int OP_W    = 2;
	localparam int PADDR_W = 64;
	localparam int FRAME_W = 10;
	localparam int STAT_W  = 3;
	localparam int AADDR_W = 22;
	localparam int PST_W   = 2;
	localparam int CNT_W   = $clog2(NUM_FRAMES + 1);

	// Bitmap storage: one row holds the used and pinned bits of WORD_W frames
	localparam int WORD_W = 32;
	localparam int BIT_W  = $clog2(WORD_W);
	localparam int ROWS   = NUM_FRAMES / WORD_W;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int IDX_W  = ROW_W + BIT_W;

	localparam int IN_DATA_W  = ((PADDR_W + FRAME_W + 2 + 7) / 8) * 8;
	localparam int OUT_FLD_W  = STAT_W + AADDR_W + PST_W + 2 * CNT_W;
	localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [ROW_W-1:0] row_t;
	typedef logic [BIT_W-1:0] bit_idx_t;
	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [OP_W-1:0] {
		OP_SETUP = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK         = 3'd0,
		ST_EXHAUSTED  = 3'd1,
		ST_INVALID    = 3'd2,
		ST_ALREADY    = 3'd3,
		ST_RESERVED   = 3'd4
	} status_t;

	typedef enum logic [PST_W-1:0] {
		PS_INVALID = 2'd0,
		PS_USED    = 2'd1,
		PS_FREE    = 2'd2
	} page_state_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EXEC,
		S_DONE
	} seq_state_t;

	typedef struct packed {
		op_t                op;
		logic [PADDR_W-1:0] page_address;
		logic [FRAME_W-1:0] frame_index;
		logic               frame_usable;
		logic               frame_reserved;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [AADDR_W-1:0] allocated_address;
		page_state_t        page_state;
		cnt_t               free_frames;
		cnt_t               used_frames;
	} res_t;

	function automatic cnt_t cnt_up(input cnt_t v);
		return (v < CNT_W'(NUM_FRAMES)) ? v + CNT_W'(1) : v;
	endfunction

	function automatic cnt_t cnt_down(input cnt_t v);
		return (v != '0) ? v - CNT_W'(1) : v;
	endfunction

endpackage
`default_nettype wire

/* hdl/pfa_zero_find.sv */
// Finds the lowest clear bit of one bitmap row.
// Depends on pfa_pkg.
`default_nettype none
module pfa_zero_find
	import pfa_pkg::*;
(
	input  var word_t    word,
	output logic         found,
	output bit_idx_t     pos
);

	always_comb begin
		found = 1'b0;
		pos   = '0;
		// scan from the top so the lowest clear bit wins
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!word[i]) begin
				found = 1'b1;
				pos   = BIT_W'(i);
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/pfa_seq.sv */
// Sequencer of the allocator: bitmap row memory, counts and per-operation steps.
// Depends on pfa_pkg and pfa_zero_find.
`default_nettype none
module pfa_seq
	import pfa_pkg::*;
(
	input  var logic clk,
	input  var logic arst_n,
	input  var logic req_valid,
	output logic     req_ready,
	input  var req_t req,
	output logic     res_valid,
	input  var logic res_take,
	output res_t     res
);

	localparam row_t LAST_ROW = row_t'(ROWS - 1);

	seq_state_t state_q, state_d;
	row_t       row_q, row_d;

	// row word: pinned bits above used bits
	logic [2*WORD_W-1:0] map_mem [ROWS];
	logic [2*WORD_W-1:0] rd_word_q;
	logic                mem_we;
	logic [2*WORD_W-1:0] mem_wd;

	op_t                op_q;
	logic [FRAME_W-1:0] frame_q;
	logic               addr_ok_q;
	logic               usable_q;
	logic               reserved_q;

	cnt_t tracked_q, tracked_d;
	cnt_t free_q, free_d;
	cnt_t used_q, used_d;
	res_t res_q, res_d;

	logic     fz_found;
	bit_idx_t fz_pos;

	word_t    used_w, pin_w;
	bit_idx_t bit_sel;

	assign used_w  = rd_word_q[WORD_W-1:0];
	assign pin_w   = rd_word_q[2*WORD_W-1:WORD_W];
	assign bit_sel = frame_q[BIT_W-1:0];

	pfa_zero_find u_zero_find (
		.word  (used_w),
		.found (fz_found),
		.pos   (fz_pos)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[row_q] <= mem_wd;
		end
		rd_word_q <= map_mem[row_q];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (row_q == LAST_ROW) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) state_d = S_READ;
			end
			S_READ: state_d = S_EXEC;
			S_EXEC: begin
				if (op_q == OP_ALLOC && !fz_found && row_q != LAST_ROW) begin
					state_d = S_READ;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (res_take) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		word_t used_n;
		word_t pin_n;
		used_n    = used_w;
		pin_n     = pin_w;
		mem_we    = 1'b0;
		mem_wd    = rd_word_q;
		row_d     = row_q;
		tracked_d = tracked_q;
		free_d    = free_q;
		used_d    = used_q;
		res_d     = res_q;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wd = {{WORD_W{1'b0}}, {WORD_W{1'b1}}};
				row_d  = row_q + ROW_W'(1);
			end
			S_IDLE: begin
				if (req.op == OP_ALLOC) begin
					row_d = '0;
				end else if (req.op == OP_SETUP) begin
					row_d = req.frame_index[IDX_W-1:BIT_W];
				end else begin
					row_d = req.page_address[PAGE_SHIFT+IDX_W-1:PAGE_SHIFT+BIT_W];
				end
			end
			S_READ: ;
			S_EXEC: begin
				res_d.status            = ST_OK;
				res_d.allocated_address = '0;
				res_d.page_state        = PS_INVALID;
				unique case (op_q)
					OP_SETUP: begin
						if (!addr_ok_q) begin
							res_d.status = ST_INVALID;
						end else if (usable_q && used_w[bit_sel] && !pin_w[bit_sel]) begin
							tracked_d = cnt_up(tracked_q);
							if (reserved_q) begin
								pin_n[bit_sel] = 1'b1;
								used_d = cnt_up(used_q);
							end else begin
								used_n[bit_sel] = 1'b0;
								free_d = cnt_up(free_q);
							end
							mem_we = 1'b1;
						end
					end
					OP_ALLOC: begin
						if (fz_found) begin
							used_n[fz_pos] = 1'b1;
							free_d = cnt_down(free_q);
							used_d = cnt_up(used_q);
							mem_we = 1'b1;
							res_d.allocated_address =
								AADDR_W'({row_q, fz_pos, {PAGE_SHIFT{1'b0}}});
						end else if (row_q == LAST_ROW) begin
							res_d.status = ST_EXHAUSTED;
						end else begin
							row_d = row_q + ROW_W'(1);
						end
					end
					OP_FREE: begin
						if (!addr_ok_q) begin
							res_d.status = ST_INVALID;
						end else if (!used_w[bit_sel]) begin
							res_d.status = ST_ALREADY;
						end else if (pin_w[bit_sel] || free_q >= tracked_q) begin
							res_d.status = ST_RESERVED;
						end else begin
							used_n[bit_sel] = 1'b0;
							free_d = cnt_up(free_q);
							used_d = cnt_down(used_q);
							mem_we = 1'b1;
						end
					end
					OP_QUERY: begin
						if (!addr_ok_q) begin
							res_d.page_state = PS_INVALID;
						end else if (used_w[bit_sel]) begin
							res_d.page_state = PS_USED;
						end else begin
							res_d.page_state = PS_FREE;
						end
					end
					default: ;
				endcase
				if (mem_we) mem_wd = {pin_n, used_n};
				res_d.free_frames = free_d;
				res_d.used_frames = used_d;
			end
			S_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			row_q     <= '0;
			tracked_q <= '0;
			free_q    <= '0;
			used_q    <= '0;
		end else begin
			state_q   <= state_d;
			row_q     <= row_d;
			tracked_q <= tracked_d;
			free_q    <= free_d;
			used_q    <= used_d;
		end
	end

	// hold the request fields for the whole operation
	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (state_q == S_IDLE && req_valid) begin
			op_q       <= req.op;
			usable_q   <= req.frame_usable;
			reserved_q <= req.frame_reserved;
			if (req.op == OP_SETUP) begin
				frame_q   <= req.frame_index;
				addr_ok_q <= ({1'b0, req.frame_index} < (FRAME_W + 1)'(NUM_FRAMES));
			end else begin
				frame_q   <= req.page_address[PAGE_SHIFT+FRAME_W-1:PAGE_SHIFT];
				addr_ok_q <= (req.page_address[PAGE_SHIFT-1:0] == '0) &&
					(req.page_address[PADDR_W-1:PAGE_SHIFT+IDX_W] == '0);
			end
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

endmodule
`default_nettype wire

/* hdl/bitmap_page_frame_allocator.sv */
// Top level of the bitmap page frame allocator: stream ports and output register.
// Depends on pfa_pkg, pfa_seq and pfa_zero_find.
//
// Requests arrive on the s_ stream (operation in s_tuser, the other fields in
// s_tdata); each gives exactly one result on the m_ stream. A transfer happens
// when tvalid and tready are both high at a rising clock edge.
// One request is worked at a time. Setup, free and query read the row of their
// frame and then act on it. Alloc scans the bitmap memory one 32-frame row at
// a time through the single read port, reading and then examining each row,
// and stops at the first row with a clear used bit or after the last row.
// s_tready returns when the result moves to the output register, so no new
// request is taken until the last result has left the sequencer.
// After arst_n is released a clearing pass over every row marks every frame
// used and unpinned; s_tready stays low until it is done. Counts reset to zero.
// The result sits in an output register: while the receiver stalls, the next
// request is still taken and worked, and its result waits in the sequencer
// until the output register is free; no further request is taken meanwhile.
`default_nettype none
module bitmap_page_frame_allocator
	import pfa_pkg::*;
(
	input  var logic                  clk,
	input  var logic                  arst_n,
	input  var logic                  s_tvalid,
	output logic                      s_tready,
	// page_address[63:0], frame_index[73:64], frame_usable[74], frame_reserved[75]
	input  var logic [IN_DATA_W-1:0]  s_tdata,
	// operation[1:0]
	input  var logic [OP_W-1:0]       s_tuser,
	output logic                      m_tvalid,
	input  var logic                  m_tready,
	// status[2:0], allocated_address[24:3], page_state[26:25],
	// free_frames[37:27], used_frames[48:38]
	output logic [OUT_DATA_W-1:0]     m_tdata
);

	req_t req;
	res_t res;
	res_t out_q;
	logic out_valid_q;
	logic res_valid;
	logic res_take;

	assign req.op             = op_t'(s_tuser);
	assign req.page_address   = s_tdata[PADDR_W-1:0];
	assign req.frame_index    = s_tdata[PADDR_W+FRAME_W-1:PADDR_W];
	assign req.frame_usable   = s_tdata[PADDR_W+FRAME_W];
	assign req.frame_reserved = s_tdata[PADDR_W+FRAME_W+1];

	pfa_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req       (req),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	// load when the output slot is empty or being drained
	assign res_take = res_valid && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - OUT_FLD_W){1'b0}},
		out_q.used_frames, out_q.free_frames, out_q.page_state,
		out_q.allocated_address, out_q.status};

endmodule
`default_nettype wire

/* tb/bitmap_page_frame_allocator_test.sv */
// Self-checking bench for bitmap_page_frame_allocator: setup, alloc, free and query requests
// go in on the s_ stream, and each result on the m_ stream is checked against a local predictor.
// Depends on pfa_pkg and the allocator RTL.
module bitmap_page_frame_allocator_test
	import pfa_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD = 400;
	localparam int LOW_FRAMES = 128;
	localparam int SETTLE_CYCLES = 80;
	localparam int RANDOM_PER_PHASE = 380;

	// m_tdata field offsets, lowest bit up
	localparam int ST_LSB = 0;
	localparam int AA_LSB = ST_LSB + STAT_W;
	localparam int PS_LSB = AA_LSB + AADDR_W;
	localparam int FF_LSB = PS_LSB + PST_W;
	localparam int UF_LSB = FF_LSB + CNT_W;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [OP_W-1:0]       s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	bitmap_page_frame_allocator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	// Predicted allocator state
	bit [NUM_FRAMES-1:0] frame_used = '1;
	bit [NUM_FRAMES-1:0] frame_pinned = '0;
	cnt_t tracked_n = '0;
	cnt_t free_n = '0;
	cnt_t used_n = '0;

	req_t request_backlog[$];
	res_t expected_results[$];

	int send_idle_pct = 9;
	int recv_idle_pct = 78;
	bit long_hold_go = 1'b0;
	bit long_hold_done = 1'b0;
	int hold_left = 0;
	logic in_xfer = 1'b0;
	int quiet_cycles = 0;
	int failures = 0;
	int ops_taken[4] = '{0, 0, 0, 0};
	int exhausted_allocs = 0;
	int frees_done = 0;

	function automatic cnt_t sat_inc(input cnt_t v);
		return (v < cnt_t'(NUM_FRAMES)) ? cnt_t'(v + 1'b1) : v;
	endfunction

	function automatic cnt_t sat_dec(input cnt_t v);
		return (v != '0) ? cnt_t'(v - 1'b1) : v;
	endfunction

	// Apply one request to the predicted state and return the result it should produce
	function automatic res_t account_request(input req_t r);
		res_t o;
		logic [PADDR_W-1:0] fr;
		logic [FRAME_W-1:0] fi;
		bit page_ok;
		int hit;
		o.status = ST_OK;
		o.allocated_address = '0;
		o.page_state = PS_INVALID;
		fr = r.page_address >> PAGE_SHIFT;
		fi = fr[FRAME_W-1:0];
		page_ok = (r.page_address[PAGE_SHIFT-1:0] == '0) && (fr < NUM_FRAMES);
		case (r.op)
			OP_SETUP: begin
				if (int'(r.frame_index) >= NUM_FRAMES) begin
					o.status = ST_INVALID;
				end else if (r.frame_usable && frame_used[r.frame_index]
						&& !frame_pinned[r.frame_index]) begin
					tracked_n = sat_inc(tracked_n);
					if (r.frame_reserved) begin
						frame_pinned[r.frame_index] = 1'b1;
						used_n = sat_inc(used_n);
					end else begin
						frame_used[r.frame_index] = 1'b0;
						free_n = sat_inc(free_n);
					end
				end
			end
			OP_ALLOC: begin
				hit = -1;
				for (int i = 0; i < NUM_FRAMES; i++)
					if (hit < 0 && !frame_used[i])
						hit = i;
				if (hit < 0) begin
					o.status = ST_EXHAUSTED;
				end else begin
					frame_used[hit] = 1'b1;
					free_n = sat_dec(free_n);
					used_n = sat_inc(used_n);
					o.allocated_address = AADDR_W'(hit << PAGE_SHIFT);
				end
			end
			OP_FREE: begin
				if (!page_ok) begin
					o.status = ST_INVALID;
				end else if (!frame_used[fi]) begin
					o.status = ST_ALREADY;
				end else if (frame_pinned[fi] || free_n >= tracked_n) begin
					o.status = ST_RESERVED;
				end else begin
					frame_used[fi] = 1'b0;
					free_n = sat_inc(free_n);
					used_n = sat_dec(used_n);
				end
			end
			default: begin
				if (!page_ok)
					o.page_state = PS_INVALID;
				else if (frame_used[fi])
					o.page_state = PS_USED;
				else
					o.page_state = PS_FREE;
			end
		endcase
		o.free_frames = free_n;
		o.used_frames = used_n;
		return o;
	endfunction

	task automatic check_field(input string fname, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", fname, want, got);
			failures++;
		end
	endtask

	task automatic queue_request(input op_t op, input logic [PADDR_W-1:0] addr,
			input logic [FRAME_W-1:0] idx, input logic usable, input logic reserved);
		req_t r;
		r.op = op;
		r.page_address = addr;
		r.frame_index = idx;
		r.frame_usable = usable;
		r.frame_reserved = reserved;
		request_backlog.push_back(r);
	endtask

	// Mostly frames in a low window so setups, allocs and frees keep colliding
	task automatic queue_random_requests(input int n);
		int pick;
		int kind;
		logic [PADDR_W-1:0] addr;
		logic [FRAME_W-1:0] idx;
		for (int k = 0; k < n; k++) begin
			kind = $urandom_range(99);
			pick = $urandom_range(99);
			if (pick < 75)
				addr = 64'($urandom_range(LOW_FRAMES - 1)) << PAGE_SHIFT;
			else if (pick < 85)
				addr = 64'($urandom_range(NUM_FRAMES - 1)) << PAGE_SHIFT;
			else if (pick < 92)
				addr = (64'($urandom_range(NUM_FRAMES - 1)) << PAGE_SHIFT)
					| 64'($urandom_range((1 << PAGE_SHIFT) - 1, 1));
			else
				addr = {$urandom, $urandom};
			if ($urandom_range(99) < 80)
				idx = FRAME_W'($urandom_range(LOW_FRAMES - 1));
			else
				idx = FRAME_W'($urandom);
			if (kind < 20)
				queue_request(OP_SETUP, {$urandom, $urandom}, idx,
					$urandom_range(99) < 85, $urandom_range(99) < 25);
			else if (kind < 55)
				queue_request(OP_ALLOC, {$urandom, $urandom}, FRAME_W'($urandom),
					1'($urandom), 1'($urandom));
			else if (kind < 85)
				queue_request(OP_FREE, addr, FRAME_W'($urandom), 1'($urandom), 1'($urandom));
			else
				queue_request(OP_QUERY, addr, FRAME_W'($urandom), 1'($urandom), 1'($urandom));
		end
	endtask

	task automatic drain_all();
		while (request_backlog.size() != 0 || expected_results.size() != 0 || s_tvalid)
			@(posedge clk);
	endtask

	// Request driver: advance to the next item once the current one has transferred
	always @(negedge clk) begin : feed
		req_t nxt;
		if (!s_tvalid || in_xfer) begin
			if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = request_backlog.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= nxt.op;
				s_tdata <= IN_DATA_W'({nxt.frame_reserved, nxt.frame_usable,
					nxt.frame_index, nxt.page_address});
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver, with one long hold to back the block up
	always @(negedge clk) begin : drain
		if (long_hold_go && !long_hold_done) begin
			long_hold_done = 1'b1;
			hold_left = LONG_HOLD;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : observe
		req_t seen;
		res_t want;
		in_xfer <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			seen.op = op_t'(s_tuser);
			seen.page_address = s_tdata[PADDR_W-1:0];
			seen.frame_index = s_tdata[PADDR_W +: FRAME_W];
			seen.frame_usable = s_tdata[PADDR_W + FRAME_W];
			seen.frame_reserved = s_tdata[PADDR_W + FRAME_W + 1];
			want = account_request(seen);
			expected_results.push_back(want);
			ops_taken[seen.op]++;
			if (want.status == ST_EXHAUSTED)
				exhausted_allocs++;
			if (seen.op == OP_FREE && want.status == ST_OK)
				frees_done++;
		end
		if (m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transfer: m_tdata=%h", m_tdata);
				failures++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", want.status, m_tdata[ST_LSB +: STAT_W]);
				check_field("allocated_address", want.allocated_address,
					m_tdata[AA_LSB +: AADDR_W]);
				check_field("page_state", want.page_state, m_tdata[PS_LSB +: PST_W]);
				check_field("free_frames", want.free_frames, m_tdata[FF_LSB +: CNT_W]);
				check_field("used_frames", want.used_frames, m_tdata[UF_LSB +: CNT_W]);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty allocator, then a handful of frames set up and worked by hand
		queue_request(OP_ALLOC, '0, '0, 1'b0, 1'b0);
		queue_request(OP_QUERY, '0, '0, 1'b0, 1'b0);
		queue_request(OP_FREE, '0, '0, 1'b0, 1'b0);
		queue_request(OP_SETUP, '1, '0, 1'b1, 1'b0);
		queue_request(OP_SETUP, '0, '1, 1'b1, 1'b1);
		queue_request(OP_SETUP, '0, 10'd5, 1'b0, 1'b1);
		queue_request(OP_SETUP, '0, '0, 1'b1, 1'b1);
		queue_request(OP_SETUP, '0, '1, 1'b1, 1'b0);
		queue_request(OP_QUERY, '0, '1, 1'b1, 1'b1);
		queue_request(OP_QUERY, 64'h1, '0, 1'b0, 1'b0);
		queue_request(OP_QUERY, 64'h40_0000, '0, 1'b0, 1'b0);
		queue_request(OP_QUERY, '1, '0, 1'b0, 1'b0);
		queue_request(OP_QUERY, 64'h3F_F000, '0, 1'b0, 1'b0);
		queue_request(OP_FREE, 64'h3F_F000, '0, 1'b0, 1'b0);
		queue_request(OP_ALLOC, '1, '1, 1'b1, 1'b1);
		queue_request(OP_SETUP, '0, 10'd2, 1'b1, 1'b0);
		queue_request(OP_FREE, 64'h1000, '0, 1'b0, 1'b0);
		queue_request(OP_FREE, 64'h2000, '0, 1'b0, 1'b0);
		queue_request(OP_FREE, 64'h800, '0, 1'b0, 1'b0);
		queue_request(OP_FREE, 64'h40_0000, '0, 1'b0, 1'b0);
		queue_request(OP_FREE, 64'h0, '0, 1'b0, 1'b0);
		repeat (4) queue_request(OP_ALLOC, '0, '0, 1'b0, 1'b0);
		queue_random_requests(RANDOM_PER_PHASE);
		drain_all();

		send_idle_pct = 78;
		recv_idle_pct = 9;
		queue_random_requests(RANDOM_PER_PHASE);
		drain_all();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		long_hold_go = 1'b1;
		queue_random_requests(RANDOM_PER_PHASE);
		drain_all();

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("requests: %0d setup, %0d alloc, %0d free, %0d query",
			ops_taken[OP_SETUP], ops_taken[OP_ALLOC], ops_taken[OP_FREE],
			ops_taken[OP_QUERY]);
		$display("%0d allocs hit an exhausted map, %0d frees returned a frame",
			exhausted_allocs, frees_done);
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* sim.f */
hdl/pfa_pkg.sv
hdl/pfa_zero_find.sv
hdl/pfa_seq.sv
hdl/bitmap_page_frame_allocator.sv
tb/bitmap_page_frame_allocator_test.sv
